>>> sv/mjdc_pkg.sv
// ----------------------------------------------------------------------------
// mjdc_pkg
// Types and constants for the MJD and BCD time to calendar converter.
// ----------------------------------------------------------------------------
package mjdc_pkg;

    localparam int MJD_W   = 16;
    localparam int BCD_W   = 8;
    localparam int YEAR_W  = 11;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int TIME_W  = 8;

    // year quotient numerator: 40*mjd - 603128 stays below 2^21 for valid dates
    localparam int NUM_W    = 21;
    localparam int YP_W     = 8;
    localparam int REM_W    = 9;
    localparam int MP_W     = 4;

    localparam logic [MJD_W-1:0] MJD_FIRST_VALID = 16'd15079;
    localparam logic [MJD_W-1:0] MJD_BASE        = 16'd14956;
    localparam int               YEAR_NUM_OFS    = 603128;
    localparam int               YEAR_DIV        = 14610;
    localparam int               YEAR_SHIFT      = 21;
    localparam int               YEAR_RECIP      = (1 << YEAR_SHIFT) / YEAR_DIV;
    localparam int               QUAD_DAYS       = 1461;
    localparam logic [YEAR_W-1:0] YEAR_BASE      = 11'd1900;

    typedef struct packed {
        logic [MJD_W-1:0] mjd;
        logic [BCD_W-1:0] hour_bcd;
        logic [BCD_W-1:0] minute_bcd;
        logic [BCD_W-1:0] second_bcd;
    } t_in_item;

    typedef struct packed {
        logic               date_valid;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [TIME_W-1:0]  hour;
        logic [TIME_W-1:0]  minute;
        logic [TIME_W-1:0]  second;
    } t_out_item;

endpackage

>>> sv/mjdc_if.sv
// ----------------------------------------------------------------------------
// mjdc_in_if / mjdc_out_if
// Valid/ready channels carrying timestamps in and calendar results out.
// ----------------------------------------------------------------------------
interface mjdc_in_if import mjdc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mjdc_out_if import mjdc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/mjdc_month_find.sv
// ----------------------------------------------------------------------------
// mjdc_month_find
// Month index from days into the March-based year, plus the days that
// precede that month, by comparison against constant thresholds.
// ----------------------------------------------------------------------------
module mjdc_month_find import mjdc_pkg::*; (
    input  logic [REM_W-1:0] i_rem,
    output logic [MP_W-1:0]  o_mp,
    output logic [REM_W-1:0] o_days_before
);

    localparam int MP_MAX = (1 << MP_W) - 1;

    // smallest rem with floor((10000*rem - 1000) / 306001) >= m
    function automatic int month_thresh(input int m);
        return (306001 * m + 1000 + 9999) / 10000;
    endfunction

    function automatic int days_before(input int m);
        return (306001 * m) / 10000;
    endfunction

    logic [MP_W-1:0] w_cnt;

    always_comb begin
        w_cnt = '0;
        for (int m = 1; m <= MP_MAX; m++) begin
            if (i_rem >= REM_W'(month_thresh(m))) begin
                w_cnt = w_cnt + MP_W'(1);
            end
        end
    end

    always_comb begin
        o_days_before = '0;
        for (int m = 0; m <= MP_MAX; m++) begin
            if (w_cnt == MP_W'(m)) begin
                o_days_before = REM_W'(days_before(m));
            end
        end
    end

    assign o_mp = w_cnt;

endmodule

>>> sv/mjd_bcd_utc_to_calendar.sv
// ----------------------------------------------------------------------------
// mjd_bcd_utc_to_calendar
// DVB MJD and BCD UTC time to calendar date and binary time.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : valid/ready sink, one transaction per timestamp (mjd plus three
//           BCD time bytes).
//   o_out : valid/ready source, one transaction per input, in order.
//   Six register stages: start of year quotient, reciprocal multiply,
//   quotient correction, day offset in year, month search, final assembly.
//   A result is offered from the final assembly register; one transaction
//   can enter every cycle unless all stages are full and the output stalls.
//   Each stage has its own valid bit and moves on when the stage after it
//   is empty or moving, so bubbles are squeezed out while the output is
//   stalled; i_in.ready drops only once every stage holds a transaction
//   and the receiver holds off.
//   Dates before 1900-03-01 (mjd below 15079) give date_valid low and zero
//   date fields; the time fields are converted regardless.
//   Reset empties the pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mjd_bcd_utc_to_calendar import mjdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mjdc_in_if.sink     i_in,
    mjdc_out_if.source  o_out
);

    function automatic logic [TIME_W-1:0] bcd_to_bin(input logic [BCD_W-1:0] v);
        logic [TIME_W-1:0] hi;
        logic [TIME_W-1:0] lo;
        hi = TIME_W'(v[7:4]);
        lo = TIME_W'(v[3:0]);
        return (hi << 3) + (hi << 1) + lo;
    endfunction

    localparam int PROD_W = NUM_W + 8;
    localparam int CHK_W  = 22;
    localparam int A_W    = 19;

    // per-stage advance
    logic [6:1] w_adv;

    assign w_adv[6] = !o_out.valid || o_out.ready;

    // valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    assign w_adv[5] = !r_v5 || w_adv[6];
    assign w_adv[4] = !r_v4 || w_adv[5];
    assign w_adv[3] = !r_v3 || w_adv[4];
    assign w_adv[2] = !r_v2 || w_adv[3];
    assign w_adv[1] = !r_v1 || w_adv[2];

    assign i_in.ready = w_adv[1];

    // time fields travel down the pipe
    logic [TIME_W-1:0] r_hr1, r_mn1, r_sc1;
    logic [TIME_W-1:0] r_hr2, r_mn2, r_sc2;
    logic [TIME_W-1:0] r_hr3, r_mn3, r_sc3;
    logic [TIME_W-1:0] r_hr4, r_mn4, r_sc4;
    logic [TIME_W-1:0] r_hr5, r_mn5, r_sc5;

    logic             r_dv1, r_dv2, r_dv3, r_dv4, r_dv5;
    logic [MJD_W-1:0] r_mjd1, r_mjd2, r_mjd3;
    logic [NUM_W-1:0] r_num1, r_num2;
    logic [YP_W-1:0]  r_q2;
    logic [YP_W-1:0]  r_yp3, r_yp4, r_yp5;
    logic [REM_W-1:0] r_rem4, r_rem5;
    logic [MP_W-1:0]  r_mp5;
    logic [REM_W-1:0] r_db5;
    t_out_item        r_out;

    // stage 1: numerator of the year quotient
    logic             n_dv1;
    logic [CHK_W-1:0] n_num1;

    always_comb begin
        n_dv1  = (i_in.data.mjd >= MJD_FIRST_VALID);
        n_num1 = CHK_W'(i_in.data.mjd) * CHK_W'(40) - CHK_W'(YEAR_NUM_OFS);
        if (!n_dv1) begin
            n_num1 = '0;
        end
    end

    // stage 2: reciprocal estimate, low by at most one
    logic [PROD_W-1:0] n_prod2;
    assign n_prod2 = PROD_W'(r_num1) * PROD_W'(YEAR_RECIP);

    // stage 3: correction of the estimate
    logic [CHK_W-1:0] n_chk3;
    logic [YP_W-1:0]  n_yp3;

    always_comb begin
        n_chk3 = CHK_W'(r_num2) - CHK_W'(r_q2) * CHK_W'(YEAR_DIV);
        n_yp3  = r_q2;
        if (n_chk3 >= CHK_W'(YEAR_DIV)) begin
            n_yp3 = r_q2 + YP_W'(1);
        end
    end

    // stage 4: days past the start of the March-based year
    logic [A_W-1:0]   n_a4;
    logic [A_W-1:0]   n_rem4;

    assign n_a4   = (A_W'(r_yp3) * A_W'(QUAD_DAYS)) >> 2;
    assign n_rem4 = A_W'(r_mjd3) - A_W'(MJD_BASE) - n_a4;

    // stage 5: month search
    logic [MP_W-1:0]  n_mp5;
    logic [REM_W-1:0] n_db5;

    mjdc_month_find u_month_find (
        .i_rem         (r_rem4),
        .o_mp          (n_mp5),
        .o_days_before (n_db5)
    );

    // stage 6: assembly
    t_out_item   n_out;
    logic        n_k6;
    logic [REM_W-1:0] n_day6;

    always_comb begin
        n_k6   = (r_mp5 == MP_W'(14)) || (r_mp5 == MP_W'(15));
        n_day6 = r_rem5 - r_db5;
        n_out.date_valid = r_dv5;
        n_out.year       = YEAR_BASE + YEAR_W'(r_yp5) + YEAR_W'(n_k6);
        n_out.month      = n_k6 ? (r_mp5 - MONTH_W'(13)) : (r_mp5 - MONTH_W'(1));
        n_out.day        = n_day6[DAY_W-1:0];
        n_out.hour       = r_hr5;
        n_out.minute     = r_mn5;
        n_out.second     = r_sc5;
        if (!r_dv5) begin
            n_out.year  = '0;
            n_out.month = '0;
            n_out.day   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_adv[1]) r_v1 <= i_in.valid;
            if (w_adv[2]) r_v2 <= r_v1;
            if (w_adv[3]) r_v3 <= r_v2;
            if (w_adv[4]) r_v4 <= r_v3;
            if (w_adv[5]) r_v5 <= r_v4;
            if (w_adv[6]) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1] && i_in.valid) begin
            r_dv1  <= n_dv1;
            r_mjd1 <= i_in.data.mjd;
            r_num1 <= n_num1[NUM_W-1:0];
            r_hr1  <= bcd_to_bin(i_in.data.hour_bcd);
            r_mn1  <= bcd_to_bin(i_in.data.minute_bcd);
            r_sc1  <= bcd_to_bin(i_in.data.second_bcd);
        end
        if (w_adv[2] && r_v1) begin
            r_dv2  <= r_dv1;
            r_mjd2 <= r_mjd1;
            r_num2 <= r_num1;
            r_q2   <= n_prod2[PROD_W-1:YEAR_SHIFT];
            r_hr2  <= r_hr1;
            r_mn2  <= r_mn1;
            r_sc2  <= r_sc1;
        end
        if (w_adv[3] && r_v2) begin
            r_dv3  <= r_dv2;
            r_mjd3 <= r_mjd2;
            r_yp3  <= n_yp3;
            r_hr3  <= r_hr2;
            r_mn3  <= r_mn2;
            r_sc3  <= r_sc2;
        end
        if (w_adv[4] && r_v3) begin
            r_dv4  <= r_dv3;
            r_yp4  <= r_yp3;
            r_rem4 <= n_rem4[REM_W-1:0];
            r_hr4  <= r_hr3;
            r_mn4  <= r_mn3;
            r_sc4  <= r_sc3;
        end
        if (w_adv[5] && r_v4) begin
            r_dv5  <= r_dv4;
            r_yp5  <= r_yp4;
            r_rem5 <= r_rem4;
            r_mp5  <= n_mp5;
            r_db5  <= n_db5;
            r_hr5  <= r_hr4;
            r_mn5  <= r_mn4;
            r_sc5  <= r_sc4;
        end
        if (w_adv[6] && r_v5) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_v6;
    assign o_out.data  = r_out;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input held off while output not stalled");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.date_valid) |->
            (o_out.data.month >= MONTH_W'(1) && o_out.data.month <= MONTH_W'(12) &&
             o_out.data.day >= DAY_W'(1) &&
             o_out.data.year >= YEAR_BASE && o_out.data.year <= YEAR_W'(2038)))
        else $error("calendar field out of range");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.date_valid) |->
            (o_out.data.year == '0 && o_out.data.month == '0 && o_out.data.day == '0))
        else $error("date fields not cleared for early date");

endmodule

>>> verif/mjdc_calendar_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mjdc_calendar_checker
// Watches both channels of the calendar converter and checks every result.
// Each accepted timestamp is turned into its expected calendar date and
// binary time and queued. Each accepted result is compared field by field
// with the oldest queued date. The failure count goes back to the top.
// ----------------------------------------------------------------------------
module mjdc_calendar_checker import mjdc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mjdc_in_if    i_ts,
    mjdc_out_if   i_res,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked,
    output int    o_early
);

    localparam int REPORT_LIMIT = 10;

    localparam longint unsigned FIRST_DATE_MJD = 15079;
    localparam longint unsigned YEAR_OFS       = 603128;
    localparam longint unsigned YEAR_DAYS_X40  = 14610;
    localparam longint unsigned LEAP_CYCLE     = 1461;
    localparam longint unsigned DAY_BASE       = 14956;
    localparam longint unsigned MONTH_SCALE    = 10000;
    localparam longint unsigned MONTH_DAYS_X   = 306001;
    localparam longint unsigned CENTURY_BASE   = 1900;

    t_out_item calendar_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_early      = 0;
    end

    function automatic logic [7:0] bin_of_bcd(logic [7:0] b);
        logic [7:0] tens;
        tens = {4'd0, b[7:4]};
        return tens * 8'd10 + {4'd0, b[3:0]};
    endfunction

    function automatic t_out_item calendar_of(t_in_item ts);
        t_out_item             c;
        longint unsigned       mjd, yp, quad, rem, mp, part, k;
        c   = '0;
        mjd = 64'(ts.mjd);
        if (mjd >= FIRST_DATE_MJD) begin
            yp   = (40 * mjd - YEAR_OFS) / YEAR_DAYS_X40;
            quad = (yp * LEAP_CYCLE) / 4;
            rem  = mjd - DAY_BASE - quad;
            mp   = (MONTH_SCALE * rem - 1000) / MONTH_DAYS_X;
            part = (mp * MONTH_DAYS_X) / MONTH_SCALE;
            // January and February count as months 14 and 15 of the year before
            k    = (mp == 14 || mp == 15) ? 1 : 0;
            c.date_valid = 1'b1;
            c.year       = YEAR_W'(yp + k + CENTURY_BASE);
            c.month      = MONTH_W'(mp - 1 - 12 * k);
            c.day        = DAY_W'(rem - part);
        end
        c.hour   = bin_of_bcd(ts.hour_bcd);
        c.minute = bin_of_bcd(ts.minute_bcd);
        c.second = bin_of_bcd(ts.second_bcd);
        return c;
    endfunction

    task automatic note_fail(string what);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT)
            $display("[%0t] checker: %s", $time, what);
    endtask

    task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
            note_fail($sformatf("result %0d %s expected %0d, got %0d",
                                o_checked, name, want, got));
    endtask

    always @(posedge i_clk) begin
        t_out_item fresh, want, got;
        if (!i_rst_n) begin
            calendar_q.delete();
        end else begin
            if (i_ts.valid && i_ts.ready) begin
                fresh = calendar_of(i_ts.data);
                calendar_q.push_back(fresh);
                if (!fresh.date_valid)
                    o_early++;
            end
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                if (calendar_q.size() == 0) begin
                    note_fail($sformatf("result with no timestamp waiting: %h", got));
                end else begin
                    want = calendar_q.pop_front();
                    field_check("date_valid", 32'(want.date_valid), 32'(got.date_valid));
                    field_check("year",       32'(want.year),       32'(got.year));
                    field_check("month",      32'(want.month),      32'(got.month));
                    field_check("day",        32'(want.day),        32'(got.day));
                    field_check("hour",       32'(want.hour),       32'(got.hour));
                    field_check("minute",     32'(want.minute),     32'(got.minute));
                    field_check("second",     32'(want.second),     32'(got.second));
                    o_checked++;
                end
            end
        end
        o_pending = calendar_q.size();
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench top for the MJD and BCD time to calendar converter.
// Sends a directed set of timestamps (calendar edges, the 1900-03-01
// boundary, non-decimal digits) and then random ones, with random idle
// bursts on both channels except in the final stretch. A checker module
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb import mjdc_pkg::*; ();

    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_TAIL    = 100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;

    logic        clk;
    logic        rst_n;
    bit          idling_on = 1'b1;
    int unsigned cycle_count = 0;
    int          fail_count, pending, checked, early;
    int          sent = 0;
    int          odd_digits = 0;
    int          stall_left = 0;

    mjdc_in_if  ts_ch ();
    mjdc_out_if res_ch ();

    mjd_bcd_utc_to_calendar uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (ts_ch),
        .o_out   (res_ch)
    );

    mjdc_calendar_checker u_cal_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_ts         (ts_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_early      (early)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("tb: FAIL");
        $finish;
    end

    function automatic logic [7:0] bcd_of(int unsigned v);
        logic [3:0] tens, ones;
        tens = 4'(v / 10);
        ones = 4'(v % 10);
        return {tens, ones};
    endfunction

    function automatic bit odd_digit(logic [7:0] b);
        return (b[7:4] > 4'd9) || (b[3:0] > 4'd9);
    endfunction

    function automatic t_in_item stamp(logic [15:0] mjd, logic [7:0] h, logic [7:0] m,
                                       logic [7:0] s);
        t_in_item ts;
        ts.mjd        = mjd;
        ts.hour_bcd   = h;
        ts.minute_bcd = m;
        ts.second_bcd = s;
        return ts;
    endfunction

    task automatic put_gap(int unsigned n);
        @(negedge clk);
        ts_ch.valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic put_timestamp(t_in_item ts);
        if (idling_on && $urandom_range(0, 4) == 0)
            put_gap($urandom_range(1, 16));
        @(negedge clk);
        ts_ch.valid <= 1'b1;
        ts_ch.data  <= ts;
        @(posedge clk);
        while (!ts_ch.ready) @(posedge clk);
        sent++;
        if (odd_digit(ts.hour_bcd) || odd_digit(ts.minute_bcd) || odd_digit(ts.second_bcd))
            odd_digits++;
    endtask

    function automatic t_in_item random_stamp();
        logic [15:0] mjd;
        logic [7:0]  h, m, s;
        case ($urandom_range(0, 9))
            0:       mjd = 16'($urandom_range(0, 15078));
            1:       mjd = 16'($urandom);
            2:       mjd = $urandom_range(0, 1) ? 16'($urandom_range(15070, 15090))
                                                : 16'($urandom_range(65500, 65535));
            default: mjd = 16'($urandom_range(15079, 65535));
        endcase
        if ($urandom_range(0, 1)) begin
            h = bcd_of($urandom_range(0, 23));
            m = bcd_of($urandom_range(0, 59));
            s = bcd_of($urandom_range(0, 60));
        end else begin
            h = 8'($urandom);
            m = 8'($urandom);
            s = 8'($urandom);
        end
        return stamp(mjd, h, m, s);
    endfunction

    // receiver: ready high, with random stall bursts while idling is on
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 16);
            end
        end
    end

    initial begin
        t_in_item directed[$];
        ts_ch.valid = 1'b0;
        ts_ch.data  = '0;
        rst_n       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed = '{
            stamp(16'd0,     8'h00, 8'h00, 8'h00),
            stamp(16'd14956, 8'h12, 8'h30, 8'h45),
            stamp(16'd15020, 8'h01, 8'h02, 8'h03),
            stamp(16'd15078, 8'h23, 8'h59, 8'h59),
            stamp(16'd15079, 8'h00, 8'h00, 8'h00),
            stamp(16'd15384, 8'h23, 8'h59, 8'h60),
            stamp(16'd15385, 8'h00, 8'h00, 8'h01),
            stamp(16'd15443, 8'h09, 8'h09, 8'h09),
            stamp(16'd51543, 8'h23, 8'h59, 8'h59),
            stamp(16'd51544, 8'h00, 8'h00, 8'h00),
            stamp(16'd51603, 8'h12, 8'h00, 8'h00),
            stamp(16'd51604, 8'h99, 8'h99, 8'h99),
            stamp(16'd45000, 8'h0F, 8'hF0, 8'hA0),
            stamp(16'h5555,  8'hAA, 8'h55, 8'h0F),
            stamp(16'hAAAA,  8'h55, 8'hAA, 8'hF0),
            stamp(16'h7FFF,  8'h5A, 8'hA5, 8'h3C),
            stamp(16'h8000,  8'hC3, 8'h96, 8'h69),
            stamp(16'd58849, 8'h12, 8'h34, 8'h56),
            stamp(16'd65534, 8'h00, 8'hFF, 8'h00),
            stamp(16'd65535, 8'hFF, 8'hFF, 8'hFF)
        };
        foreach (directed[i])
            put_timestamp(directed[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - CALM_TAIL)
                idling_on = 1'b0;
            put_timestamp(random_stamp());
        end
        @(negedge clk);
        ts_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d timestamps sent, %0d before 1900-03-01, %0d with non-decimal digits",
                 sent, early, odd_digits);
        $display("tb: %0d results compared; idle bursts on both channels, last %0d back to back",
                 checked, CALM_TAIL);
        if (fail_count == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
